### sv/pmtk_pkg.sv
// ----------------------------------------------------------------------------
// pmtk_pkg
// Types and constants shared by the peak detector and its top-K list.
// ----------------------------------------------------------------------------
package pmtk_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int PEAK_INDEX_W = 11;
  localparam int DIST_W       = 11;
  localparam int MAXPK_W      = 5;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;

  localparam int MAX_POINTS_DEF = 2048;
  localparam int TOP_DEPTH_DEF  = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DISTANCE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PEAKS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_THRESHOLD = 2'd2;

  // Reset values of the configuration registers (threshold 0.03 in Q1.14)
  localparam logic [DIST_W-1:0]          MIN_DISTANCE_RST  = 11'd20;
  localparam logic [MAXPK_W-1:0]         MAX_PEAKS_RST     = 5'd16;
  localparam logic signed [SAMPLE_W-1:0] MIN_THRESHOLD_RST = 16'sd492;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    sample_t sample;
    logic    end_of_frame;
  } in_item_t;

  typedef struct packed {
    logic [PEAK_INDEX_W-1:0] peak_index;
    sample_t                 peak_value;
    logic                    peak_valid;
    logic                    last_result;
  } out_item_t;

  // One peak: list entry or released peak
  typedef struct packed {
    logic                    vld;
    logic [PEAK_INDEX_W-1:0] idx;
    sample_t                 val;
  } entry_t;

  // Events that one accepted sample hands to the list stage
  typedef struct packed {
    entry_t r1;   // peak released by a far newer peak
    entry_t r2;   // held peak released at frame end
    logic   eof;
  } ev_t;

endpackage

### sv/pmtk_front.sv
// ----------------------------------------------------------------------------
// pmtk_front
// Sample window, local-maximum test and merging of close peaks.
// ----------------------------------------------------------------------------
module pmtk_front #(
  parameter int MAX_POINTS = pmtk_pkg::MAX_POINTS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           accept_i,
  input  pmtk_pkg::in_item_t             item_i,
  input  logic [pmtk_pkg::DIST_W-1:0]    min_distance_i,
  output pmtk_pkg::ev_t                  ev_o
);
  import pmtk_pkg::*;

  localparam int IdxW  = $clog2(MAX_POINTS);
  localparam int CntW  = $clog2(MAX_POINTS + 2);
  localparam int DiffW = (IdxW > DIST_W) ? IdxW : DIST_W;

  sample_t         prev_q, earlier_q;
  logic [CntW-1:0] cnt_q;
  logic [IdxW-1:0] hidx_q, hidx_d;
  sample_t         hval_q, hval_d;
  logic            hpres_q, hpres_d;

  logic            is_peak, far;
  logic [IdxW-1:0] pidx, span;
  entry_t          r1, r2;

  assign is_peak = (cnt_q >= CntW'(2)) && (cnt_q <= CntW'(MAX_POINTS)) &&
                   (prev_q > earlier_q) && (prev_q > item_i.sample);
  assign pidx    = IdxW'(cnt_q - CntW'(1));
  assign span    = pidx - hidx_q;
  assign far     = DiffW'(span) > DiffW'(min_distance_i);

  always_comb begin
    hidx_d  = hidx_q;
    hval_d  = hval_q;
    hpres_d = hpres_q;
    r1      = '0;
    if (is_peak) begin
      if (!hpres_q) begin
        hpres_d = 1'b1;
        hidx_d  = pidx;
        hval_d  = prev_q;
      end else if (far) begin
        r1.vld = 1'b1;
        r1.idx = PEAK_INDEX_W'(hidx_q);
        r1.val = hval_q;
        hidx_d = pidx;
        hval_d = prev_q;
      end else if (prev_q > hval_q) begin
        hidx_d = pidx;
        hval_d = prev_q;
      end
    end
    // release whatever is held once the frame ends
    r2.vld = item_i.end_of_frame & hpres_d;
    r2.idx = PEAK_INDEX_W'(hidx_d);
    r2.val = hval_d;
  end

  assign ev_o.r1  = r1;
  assign ev_o.r2  = r2;
  assign ev_o.eof = item_i.end_of_frame;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q    <= '0;
      earlier_q <= '0;
      cnt_q     <= '0;
      hidx_q    <= '0;
      hval_q    <= '0;
      hpres_q   <= 1'b0;
    end else if (accept_i) begin
      if (item_i.end_of_frame) begin
        prev_q    <= '0;
        earlier_q <= '0;
        cnt_q     <= '0;
        hidx_q    <= '0;
        hval_q    <= '0;
        hpres_q   <= 1'b0;
      end else begin
        prev_q    <= item_i.sample;
        earlier_q <= prev_q;
        if (cnt_q <= CntW'(MAX_POINTS)) begin
          cnt_q <= cnt_q + CntW'(1);
        end
        hidx_q  <= hidx_d;
        hval_q  <= hval_d;
        hpres_q <= hpres_d;
      end
    end
  end

endmodule

### sv/pmtk_cell.sv
// ----------------------------------------------------------------------------
// pmtk_cell
// One slot of the sorted top-K chain: compare with the offered peak, then
// keep, take the offered peak, or take the left neighbor's entry.
// ----------------------------------------------------------------------------
module pmtk_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pmtk_pkg::entry_t ins_i,     // vld high: insert this peak
  input  logic             left_ge_i, // left neighbor stays ahead of ins_i
  input  pmtk_pkg::entry_t left_i,    // left neighbor, vld within the limit
  input  logic             lim_i,     // slot lies below the list limit
  input  logic             clear_i,
  output pmtk_pkg::entry_t ent_o,     // vld within the limit
  output logic             ge_o,
  output pmtk_pkg::entry_t nxt_o      // next content, vld within the limit
);
  import pmtk_pkg::*;

  logic    vld_q;
  sample_t val_q;
  logic [PEAK_INDEX_W-1:0] idx_q;
  logic    eff;
  entry_t  nxt;

  assign eff  = vld_q & lim_i;
  assign ge_o = eff && (val_q >= ins_i.val);

  always_comb begin
    if (!ins_i.vld) begin
      nxt = '{vld: vld_q, idx: idx_q, val: val_q};
    end else if (ge_o) begin
      nxt = '{vld: eff, idx: idx_q, val: val_q};
    end else if (left_ge_i) begin
      nxt = '{vld: lim_i, idx: ins_i.idx, val: ins_i.val};
    end else begin
      nxt = '{vld: lim_i & left_i.vld, idx: left_i.idx, val: left_i.val};
    end
  end

  assign ent_o = '{vld: eff, idx: idx_q, val: val_q};
  assign nxt_o = '{vld: nxt.vld & lim_i, idx: nxt.idx, val: nxt.val};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= clear_i ? 1'b0 : nxt.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= nxt.idx;
    val_q <= nxt.val;
  end

endmodule

### sv/pmtk_outq.sv
// ----------------------------------------------------------------------------
// pmtk_outq
// Result buffer: loads a finished list at once and shifts it out one
// transaction at a time.
// ----------------------------------------------------------------------------
module pmtk_outq #(
  parameter int TOP_DEPTH = pmtk_pkg::TOP_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  pmtk_pkg::entry_t    load_ent_i [TOP_DEPTH],
  output logic                busy_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pmtk_pkg::out_item_t out_data_o
);
  import pmtk_pkg::*;

  logic [TOP_DEPTH-1:0] occ_q, occ_d, load_occ;
  logic [TOP_DEPTH:0]   occ_ext;
  logic                 pv_q, any_vld, pop;
  entry_t               ent_q [TOP_DEPTH];

  always_comb begin
    for (int k = 0; k < TOP_DEPTH; k++) begin
      load_occ[k] = load_ent_i[k].vld;
    end
  end

  assign any_vld = |load_occ;
  assign occ_ext = {1'b0, occ_q};
  assign pop     = occ_q[0] & out_ready_i;

  always_comb begin
    if (load_i) begin
      // an empty list still gives one invalid result
      occ_d = any_vld ? load_occ : TOP_DEPTH'(1);
    end else if (pop) begin
      occ_d = occ_ext[TOP_DEPTH:1];
    end else begin
      occ_d = occ_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
      pv_q  <= 1'b0;
    end else begin
      occ_q <= occ_d;
      if (load_i) begin
        pv_q <= any_vld;
      end
    end
  end

  for (genvar k = 0; k < TOP_DEPTH; k++) begin : g_slot
    entry_t ld, sh;
    assign ld = (any_vld || k != 0) ? load_ent_i[k] : '0;
    if (k < TOP_DEPTH - 1) begin : g_mid
      assign sh = ent_q[k+1];
    end else begin : g_end
      assign sh = ent_q[k];
    end
    always_ff @(posedge clk_i) begin
      if (load_i) begin
        ent_q[k] <= ld;
      end else if (pop) begin
        ent_q[k] <= sh;
      end
    end
  end

  assign busy_o                 = occ_q[0];
  assign out_valid_o            = occ_q[0];
  assign out_data_o.peak_index  = ent_q[0].idx;
  assign out_data_o.peak_value  = ent_q[0].val;
  assign out_data_o.peak_valid  = pv_q;
  assign out_data_o.last_result = ~occ_ext[1];

endmodule

### sv/peak_merge_topk_detector.sv
// ----------------------------------------------------------------------------
// peak_merge_topk_detector
// Local-maximum peak detector with merging of close peaks and a sorted
// top-K list built in a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Throughput: one sample per cycle while not stalled; each chain cell
//   inserts one peak a cycle. A frame end that releases two peaks inserts
//   both before the list loads into the output buffer; results then leave
//   one per cycle while out_ready_i is high. Input stalls after an end of
//   frame with two releases, and while a frame end waits on the busy buffer.
// Reset: registers 20 / 16 / 492, frame state cleared, list and buffer empty.
module peak_merge_topk_detector #(
  parameter int MAX_POINTS = pmtk_pkg::MAX_POINTS_DEF,
  parameter int TOP_DEPTH  = pmtk_pkg::TOP_DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pmtk_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [pmtk_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  pmtk_pkg::in_item_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output pmtk_pkg::out_item_t                 out_data_o
);
  import pmtk_pkg::*;

  logic [DIST_W-1:0]  min_distance_q;
  logic [MAXPK_W-1:0] max_peaks_q;
  sample_t            min_threshold_q;

  ev_t    front_ev, ev_q, ev_d;
  logic   accept, both_rel, copy, ob_busy;
  entry_t sel, ins;

  entry_t               cell_ent [TOP_DEPTH];
  entry_t               cell_nxt [TOP_DEPTH];
  logic [TOP_DEPTH-1:0] cell_ge, cell_lim, cell_eff;

  // Configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_distance_q  <= MIN_DISTANCE_RST;
      max_peaks_q     <= MAX_PEAKS_RST;
      min_threshold_q <= MIN_THRESHOLD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MIN_DISTANCE:  min_distance_q  <= cfg_data_i[DIST_W-1:0];
        CFG_MAX_PEAKS:     max_peaks_q     <= cfg_data_i[MAXPK_W-1:0];
        CFG_MIN_THRESHOLD: min_threshold_q <= sample_t'(cfg_data_i[SAMPLE_W-1:0]);
        default: ;
      endcase
    end
  end

  pmtk_front #(.MAX_POINTS(MAX_POINTS)) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .item_i         (in_data_i),
    .min_distance_i (min_distance_q),
    .ev_o           (front_ev)
  );

  // Event stage: one insertion per cycle, then hand the list to the buffer
  assign both_rel   = ev_q.r1.vld & ev_q.r2.vld;
  assign copy       = ev_q.eof & ~both_rel & ~ob_busy;
  assign in_ready_o = ~both_rel & (~ev_q.eof | ~ob_busy);
  assign accept     = in_valid_i & in_ready_o;

  assign sel = ev_q.r1.vld ? ev_q.r1 : ev_q.r2;
  assign ins = '{vld: sel.vld && (sel.val >= min_threshold_q),
                 idx: sel.idx, val: sel.val};

  always_comb begin
    ev_d = ev_q;
    if (ev_q.r1.vld) begin
      ev_d.r1.vld = 1'b0;
    end else begin
      ev_d.r2.vld = 1'b0;
    end
    if (copy) begin
      ev_d.eof = 1'b0;
    end
    if (accept) begin
      ev_d = front_ev;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_q <= '0;
    end else begin
      ev_q <= ev_d;
    end
  end

  // Chain of list cells, highest value at slot 0
  for (genvar k = 0; k < TOP_DEPTH; k++) begin : g_cell
    entry_t left;
    logic   left_ge;
    assign cell_lim[k] = 32'(max_peaks_q) > 32'(k);
    assign cell_eff[k] = cell_ent[k].vld;
    if (k == 0) begin : g_head
      assign left    = '0;
      assign left_ge = 1'b1;
    end else begin : g_body
      assign left    = cell_ent[k-1];
      assign left_ge = cell_ge[k-1];
    end
    pmtk_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ins_i     (ins),
      .left_ge_i (left_ge),
      .left_i    (left),
      .lim_i     (cell_lim[k]),
      .clear_i   (copy),
      .ent_o     (cell_ent[k]),
      .ge_o      (cell_ge[k]),
      .nxt_o     (cell_nxt[k])
    );
  end

  pmtk_outq #(.TOP_DEPTH(TOP_DEPTH)) u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (copy),
    .load_ent_i  (cell_nxt),
    .busy_o      (ob_busy),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Live list entries always form a prefix of the chain
  a_list_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot({1'b0, cell_eff} + (TOP_DEPTH + 1)'(1)))
    else $error("list entries not contiguous");

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.peak_valid |->
      out_data_o.last_result && out_data_o.peak_index == '0 &&
      out_data_o.peak_value == '0)
    else $error("invalid result not a lone zero item");

  a_eof_reaches_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_data_i.end_of_frame |=> ev_q.eof)
    else $error("frame end lost");

  a_end_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_q.r2.vld |-> ev_q.eof)
    else $error("held peak released outside frame end");

  a_ready_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ev_q.r1.vld || ev_q.r2.vld || ev_q.eof) |-> in_ready_o)
    else $error("input stalled with empty event stage");

endmodule
